// ----- sv/emboss_filter_3x3_defines.svh -----
// ----------------------------------------------------------------------------
// emboss filter assertion macros
// shared property wrappers for the emboss filter checks
// ----------------------------------------------------------------------------
`ifndef EMBOSS_FILTER_3X3_DEFINES_SVH
`define EMBOSS_FILTER_3X3_DEFINES_SVH

// same-cycle implication, disabled during reset
`define EMB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define EMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/emb3x3_pkg.sv -----
// ----------------------------------------------------------------------------
// emb3x3_pkg
// constants, types and the grey conversion shared by the emboss filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package emb3x3_pkg;

    // line length and frame height limits
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int ROW_W         = 12;

    // configuration port
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd1024;

    // grey value: unsigned, 8 integer and 16 fraction bits
    localparam int GREY_W  = 24;
    localparam int FRAC_W  = 16;
    localparam int CHAN_W  = 8;

    localparam logic [15:0] WEIGHT_R = 16'd13933;
    localparam logic [15:0] WEIGHT_G = 16'd46871;
    localparam logic [15:0] WEIGHT_B = 16'd4732;

    // signed kernel sum width, covers -4 to +4 full-scale greys plus bias
    localparam int SUM_W = 28;
    localparam logic [SUM_W-1:0] BIAS = 28'(128) << FRAC_W;

    typedef logic [GREY_W-1:0] grey_t;

    // per-pixel control flags carried down the pipe
    typedef struct packed {
        logic has_result;
        logic row_end;
        logic frame_end;
    } pix_flags_t;

    // weighted rgb to grey, exact in 24 bits
    function automatic grey_t grey_of(input logic [CHAN_W-1:0] red,
                                      input logic [CHAN_W-1:0] green,
                                      input logic [CHAN_W-1:0] blue);
        grey_t pr;
        grey_t pg;
        grey_t pb;
        pr = GREY_W'(red)   * GREY_W'(WEIGHT_R);
        pg = GREY_W'(green) * GREY_W'(WEIGHT_G);
        pb = GREY_W'(blue)  * GREY_W'(WEIGHT_B);
        return pr + pg + pb;
    endfunction

endpackage

`default_nettype wire

// ----- sv/emb3x3_line_store.sv -----
// ----------------------------------------------------------------------------
// emb3x3_line_store
// two-row line buffer, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module emb3x3_line_store
    import emb3x3_pkg::*;
#(
    parameter int DEPTH  = MAX_WIDTH_DEF,
    parameter int DATA_W = 2 * GREY_W
) (
    input  wire logic                     aclk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- sv/emboss_filter_3x3.sv -----
// ----------------------------------------------------------------------------
// emboss_filter_3x3
// streaming 3x3 emboss filter on rgb pixels with grey conversion
// ----------------------------------------------------------------------------
// channel   handshake           payload                                 dir
// pixel     s_valid / s_ready   s_red, s_green, s_blue                  in
// result    m_valid / m_ready   m_emboss_value, m_row_end, m_frame_end  out
// config    cfg_wr_en           cfg_index, cfg_wr_data                  in
//
// one pixel per clock sustained while the result side is not stalled; a result
// word passes through the input register (grey and partial sum), the sum
// register and the output register
// the line store has one read and one write port: read on accept, written
// when the pixel leaves the grey stage
// reset clears counts, valids and the window; config returns to 1024 x 1024;
// the line store is not cleared
// a stalled result word backs up through the stages before s_ready drops
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "emboss_filter_3x3_defines.svh"

module emboss_filter_3x3
    import emb3x3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_wr_data,

    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [CHAN_W-1:0]       s_red,
    input  wire logic [CHAN_W-1:0]       s_green,
    input  wire logic [CHAN_W-1:0]       s_blue,

    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic      [CHAN_W-1:0]       m_emboss_value,
    output logic                         m_row_end,
    output logic                         m_frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    // configuration registers
    logic [CFG_WIDTH_W-1:0]  cfg_width_reg;
    logic [CFG_HEIGHT_W-1:0] cfg_height_reg;

    // position counters
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic [COL_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;
    logic [COL_W-1:0] c_eff;
    logic [ROW_W-1:0] r_eff;
    logic             last_col;
    logic             last_row;
    pix_flags_t       in_flags;

    // handshake
    logic acc;
    logic out_ready;
    logic s2_ready;
    logic adv1;

    // grey stage
    logic              v1_reg;
    logic [CHAN_W-1:0] red1_reg;
    logic [CHAN_W-1:0] green1_reg;
    logic [CHAN_W-1:0] blue1_reg;
    pix_flags_t        flags1_reg;
    logic [COL_W-1:0]  addr1_reg;
    grey_t             up1;
    grey_t             lo1;
    grey_t             grey_cur;
    logic [2*GREY_W-1:0] ls_rd_data;

    // window of grey values, columns c-2 (w0, w1) and c-1 (w3, w4, w5)
    grey_t w0_reg;
    grey_t w1_reg;
    grey_t w3_reg;
    grey_t w4_reg;
    grey_t w5_reg;

    logic [SUM_W-1:0] pos_sum;
    logic [SUM_W-1:0] neg_sum;
    logic [SUM_W-1:0] partial;

    // sum stage
    logic             v2_reg;
    logic [SUM_W-1:0] part2_reg;
    grey_t            grey2_reg;
    logic             row_end2_reg;
    logic             frame_end2_reg;
    logic [SUM_W-1:0] total;
    logic [CHAN_W-1:0] emboss_next;

    // output register
    logic              m_valid_reg;
    logic [CHAN_W-1:0] m_emboss_value_reg;
    logic              m_row_end_reg;
    logic              m_frame_end_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= WIDTH_RESET;
            cfg_height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_width_reg  <= cfg_wr_data[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: cfg_height_reg <= cfg_wr_data[CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // last column index from the width, held to 3..MAX_WIDTH
    always_comb begin
        if (cfg_width_reg < CFG_WIDTH_W'(3)) begin
            w_last = COL_W'(2);
        end else if (32'(cfg_width_reg) > 32'(MAX_WIDTH)) begin
            w_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            w_last = COL_W'(cfg_width_reg - CFG_WIDTH_W'(1));
        end
    end

    // last row index from the height, held to 3..MAX_HEIGHT
    always_comb begin
        if (cfg_height_reg < CFG_HEIGHT_W'(3)) begin
            h_last = ROW_W'(2);
        end else if (cfg_height_reg > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
            h_last = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            h_last = ROW_W'(cfg_height_reg - CFG_HEIGHT_W'(1));
        end
    end

    // position of the incoming pixel and its flags
    assign c_eff    = (col_reg > w_last) ? w_last : col_reg;
    assign r_eff    = (row_reg > h_last) ? h_last : row_reg;
    assign last_col = (c_eff == w_last);
    assign last_row = (r_eff == h_last);

    assign in_flags.has_result = (r_eff >= ROW_W'(2)) && (c_eff >= COL_W'(2));
    assign in_flags.row_end    = last_col;
    assign in_flags.frame_end  = last_col && last_row;

    always_comb begin
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : r_eff + ROW_W'(1);
        end else begin
            col_next = c_eff + COL_W'(1);
            row_next = r_eff;
        end
    end

    // flow control, stages drain independently
    assign out_ready = !m_valid_reg || m_ready;
    assign s2_ready  = !v2_reg || out_ready;
    assign adv1      = v1_reg && (!flags1_reg.has_result || s2_ready);
    assign s_ready   = !v1_reg || adv1;
    assign acc       = s_valid && s_ready;

    // counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (acc) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (acc) begin
            v1_reg <= 1'b1;
        end else if (adv1) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            red1_reg   <= s_red;
            green1_reg <= s_green;
            blue1_reg  <= s_blue;
            flags1_reg <= in_flags;
            addr1_reg  <= c_eff;
        end
    end

    // line store: upper row in the high half, lower row in the low half
    emb3x3_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2 * GREY_W)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (acc),
        .rd_addr (c_eff),
        .rd_data (ls_rd_data),
        .wr_en   (adv1),
        .wr_addr (addr1_reg),
        .wr_data ({lo1, grey_cur})
    );

    assign up1      = ls_rd_data[2*GREY_W-1:GREY_W];
    assign lo1      = ls_rd_data[GREY_W-1:0];
    assign grey_cur = grey_of(red1_reg, green1_reg, blue1_reg);

    // partial kernel sum over the stored window and the lower-line tap
    assign pos_sum = SUM_W'(lo1) + SUM_W'(w5_reg);
    assign neg_sum = SUM_W'(w3_reg) + SUM_W'(w1_reg) + (SUM_W'(w0_reg) << 1);
    assign partial = pos_sum - neg_sum;

    // window shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w0_reg <= '0;
            w1_reg <= '0;
            w3_reg <= '0;
            w4_reg <= '0;
            w5_reg <= '0;
        end else if (adv1) begin
            w0_reg <= w3_reg;
            w1_reg <= w4_reg;
            w3_reg <= up1;
            w4_reg <= lo1;
            w5_reg <= grey_cur;
        end
    end

    // sum stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv1 && flags1_reg.has_result) begin
            v2_reg <= 1'b1;
        end else if (out_ready) begin
            v2_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && flags1_reg.has_result) begin
            part2_reg      <= partial;
            grey2_reg      <= grey_cur;
            row_end2_reg   <= flags1_reg.row_end;
            frame_end2_reg <= flags1_reg.frame_end;
        end
    end

    // final sum with bias, clamp to 0..255 and keep the integer part
    assign total = part2_reg + (SUM_W'(grey2_reg) << 1) + BIAS;

    always_comb begin
        if (total[SUM_W-1]) begin
            emboss_next = '0;
        end else if (total[SUM_W-2:GREY_W] != '0) begin
            emboss_next = '1;
        end else begin
            emboss_next = total[GREY_W-1:FRAC_W];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (v2_reg && out_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (v2_reg && out_ready) begin
            m_emboss_value_reg <= emboss_next;
            m_row_end_reg      <= row_end2_reg;
            m_frame_end_reg    <= frame_end2_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_emboss_value = m_emboss_value_reg;
    assign m_row_end      = m_row_end_reg;
    assign m_frame_end    = m_frame_end_reg;

    // checks
    `EMB_ASSERT_NEXT(a_result_enters_sum, aclk, aresetn, adv1 && flags1_reg.has_result, v2_reg, "result word lost entering the sum stage")
    `EMB_ASSERT_NEXT(a_sum_held_on_stall, aclk, aresetn, v2_reg && !out_ready, v2_reg, "sum stage dropped a word under stall")
    `EMB_ASSERT_SAME(a_out_from_sum, aclk, aresetn, $rose(m_valid_reg), $past(v2_reg), "output word without a sum stage word")
    `EMB_ASSERT_SAME(a_block_on_full, aclk, aresetn, v1_reg && flags1_reg.has_result && !s2_ready, !s_ready, "pixel taken while the grey stage is blocked")
    `EMB_ASSERT_SAME(a_frame_has_row_end, aclk, aresetn, m_valid_reg && m_frame_end_reg, m_row_end_reg, "frame end without row end")

endmodule

`default_nettype wire
